### sv/ase_pkg.sv
package ase_pkg;

  localparam int unsigned NUM_ALARMS_DEF = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned TIME_W         = 64;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_DISARM = 2'd1,
    OP_RING   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_FIRED = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  // Scan record handed from cell to cell
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] best;
    logic [IDX_W-1:0]  best_id;
    logic              any;
  } scan_rec_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  id;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now;
  } fire_t;

  typedef struct packed {
    logic              en;
    logic              arm;
    logic              disarm;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] wdata;
  } cell_ctrl_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now;
    logic              none;
    logic              last;
  } rsp_t;

endpackage

### sv/ase_req_if.sv
interface ase_req_if import ase_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [IDX_W-1:0]  alarm_index;
  logic [TIME_W-1:0] time_value;

  modport source (output valid, output op, output alarm_index, output time_value,
                  input ready);
  modport sink   (input valid, input op, input alarm_index, input time_value,
                  output ready);
endinterface

### sv/ase_rsp_if.sv
interface ase_rsp_if import ase_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [IDX_W-1:0]  result_index;
  logic [TIME_W-1:0] expiry_time;
  logic [TIME_W-1:0] now_time;
  logic              none_armed;
  logic              last_result;

  modport source (output valid, output result_kind, output result_index,
                  output expiry_time, output now_time, output none_armed,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input result_index,
                  input expiry_time, input now_time, input none_armed,
                  input last_result, output ready);
endinterface

### sv/ase_cell.sv
module ase_cell import ase_pkg::*; #(
  parameter int unsigned ID = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       rec_valid_i,
  input  scan_rec_t  rec_i,
  output logic       rec_valid_o,
  output scan_rec_t  rec_o,
  output fire_t      fire_o
);

  // ids past the index range can never be armed
  localparam logic             MAPPED = (ID < (1 << IDX_W));
  localparam logic [IDX_W-1:0] MY_ID  = IDX_W'(ID);

  logic              armed_q, armed_d;
  logic [TIME_W-1:0] expiry_q;
  logic              rec_valid_q;
  scan_rec_t         rec_q, rec_d;
  logic              sel;
  logic [TIME_W-1:0] cmp_val;
  logic              less;
  logic              hit;

  assign sel = MAPPED && (ctrl_i.idx == MY_ID);

  always_comb begin
    cmp_val = (rec_i.op == OP_RING) ? rec_i.now : rec_i.best;
    less    = expiry_q < cmp_val;
    hit     = rec_valid_i && (rec_i.op == OP_RING) && armed_q && less;
  end

  always_comb begin
    rec_d = rec_i;
    if (rec_i.op == OP_QUERY && armed_q) begin
      rec_d.any = 1'b1;
      if (less) begin
        rec_d.best    = expiry_q;
        rec_d.best_id = MY_ID;
      end
    end
  end

  always_comb begin
    armed_d = armed_q;
    if (ctrl_i.arm && sel) begin
      armed_d = 1'b1;
    end else if (ctrl_i.disarm && sel) begin
      armed_d = 1'b0;
    end else if (ctrl_i.en && hit) begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
      if (ctrl_i.en) begin
        rec_valid_q <= rec_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.arm && sel) begin
      expiry_q <= ctrl_i.wdata;
    end
    if (ctrl_i.en) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o   = rec_valid_q;
  assign rec_o         = rec_q;
  assign fire_o.hit    = hit;
  assign fire_o.id     = MY_ID;
  assign fire_o.expiry = expiry_q;
  assign fire_o.now    = rec_i.now;

endmodule

### sv/alarm_set_expiry_scan_core.sv
// Arm and disarm act at the edge that accepts the item, one per cycle while no scan is under way;
// no result. Ring and query: the item walks the cell row one alarm per cycle unless the output
// stalls; the query answer passes the entry register and each cell register, then the output register.
// A ring result waits for the next fire or the end of the row, so the last one
// lands when the record leaves the row, later if the output is held off.
// No new item is taken while a record is in the row or a fire is pending. Reset clears armed bits.
module alarm_set_expiry_scan_core import ase_pkg::*; #(
  parameter int unsigned NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ase_req_if.sink   req_i,
  ase_rsp_if.source rsp_o
);

  scan_rec_t         rec   [NUM_ALARMS+1];
  logic [NUM_ALARMS:0] rec_v;
  fire_t             fire  [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] fire_hit;

  logic       rec0_valid_q, rec0_valid_d;
  scan_rec_t  rec0_q;
  logic       pend_valid_q, pend_valid_d;
  fire_t      pend_q;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q, out_d;

  op_e        req_op;
  logic       in_ready;
  logic       accept;
  logic       start_scan;
  cell_ctrl_t ctrl;
  fire_t      fire_sel;
  logic       end_v;
  scan_rec_t  end_rec;
  logic       end_query;
  logic       end_emit;
  logic       out_free;
  logic       stall;
  logic       load;

  assign req_op     = op_e'(req_i.op);
  assign in_ready   = !(|rec_v) && !pend_valid_q;
  assign accept     = req_i.valid && in_ready;
  assign start_scan = accept && (req_op == OP_RING || req_op == OP_QUERY);

  assign rec[0]   = rec0_q;
  assign rec_v[0] = rec0_valid_q;

  assign ctrl.en     = !stall;
  assign ctrl.arm    = accept && (req_op == OP_ARM);
  assign ctrl.disarm = accept && (req_op == OP_DISARM);
  assign ctrl.idx    = req_i.alarm_index;
  assign ctrl.wdata  = req_i.time_value;

  for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
    ase_cell #(.ID(i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .rec_valid_i (rec_v[i]),
      .rec_i       (rec[i]),
      .rec_valid_o (rec_v[i+1]),
      .rec_o       (rec[i+1]),
      .fire_o      (fire[i])
    );
    assign fire_hit[i] = fire[i].hit;
  end

  // only the cell holding the record can fire
  always_comb begin
    fire_sel = '0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (fire[i].hit) begin
        fire_sel = fire[i];
      end
    end
  end

  assign end_v     = rec_v[NUM_ALARMS];
  assign end_rec   = rec[NUM_ALARMS];
  assign end_query = end_rec.op == OP_QUERY;
  assign end_emit  = end_v && (end_query || pend_valid_q);
  assign out_free  = !out_valid_q || rsp_o.ready;

  // a fire is held back until the next fire or the end of the row so the final one can carry the last flag
  assign stall = !out_free && ((fire_sel.hit && pend_valid_q) || end_emit);
  assign load  = !stall && ((fire_sel.hit && pend_valid_q) || end_emit);

  always_comb begin
    out_d        = out_q;
    out_d.kind   = KIND_FIRED;
    out_d.index  = pend_q.id;
    out_d.expiry = pend_q.expiry;
    out_d.now    = pend_q.now;
    out_d.none   = 1'b0;
    out_d.last   = end_v;
    if (end_v && end_query) begin
      out_d.kind   = KIND_QUERY;
      out_d.index  = end_rec.any ? end_rec.best_id : '0;
      out_d.expiry = end_rec.any ? end_rec.best : '0;
      out_d.now    = '0;
      out_d.none   = !end_rec.any;
      out_d.last   = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (!stall && fire_sel.hit) begin
      pend_valid_d = 1'b1;
    end else if (!stall && end_v) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    rec0_valid_d = rec0_valid_q;
    if (start_scan) begin
      rec0_valid_d = 1'b1;
    end else if (!stall) begin
      rec0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec0_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rec0_valid_q <= rec0_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      rec0_q.op      <= req_op;
      rec0_q.now     <= req_i.time_value;
      rec0_q.best    <= '1;
      rec0_q.best_id <= '0;
      rec0_q.any     <= 1'b0;
    end
    if (!stall && fire_sel.hit) begin
      pend_q <= fire_sel;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_kind  = out_q.kind;
  assign rsp_o.result_index = out_q.index;
  assign rsp_o.expiry_time  = out_q.expiry;
  assign rsp_o.now_time     = out_q.now;
  assign rsp_o.none_armed   = out_q.none;
  assign rsp_o.last_result  = out_q.last;

  a_one_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(rec_v))
    else $error("more than one scan record in the cell row");

  a_one_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fire_hit))
    else $error("several cells fired in one cycle");

  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|fire_hit) |-> !in_ready)
    else $error("cell fired while the block was idle");

  a_query_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.result_kind) |-> rsp_o.last_result)
    else $error("query answer without last flag");

endmodule

### sim/alarm_scan_checker.sv
`timescale 1ns / 1ps

module alarm_scan_checker import ase_pkg::*; #(
  parameter int unsigned NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ase_req_if          req_mon,
  ase_rsp_if          rsp_mon,
  output int unsigned fail_count_o = 0,
  output int unsigned pending_o = 0
);

  logic [NUM_ALARMS-1:0] armed_q;
  logic [TIME_W-1:0]     expiry_q [NUM_ALARMS];
  rsp_t                  due_results [$];

  task automatic apply_alarm_item(input op_e op, input logic [IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0] tv);
    rsp_t              r;
    logic [TIME_W-1:0] best;
    logic [IDX_W-1:0]  best_id;
    int                fired;
    fired = 0;
    case (op)
      OP_ARM: begin
        if (32'(idx) < NUM_ALARMS) begin
          expiry_q[idx] = tv;
          armed_q[idx]  = 1'b1;
        end
      end
      OP_DISARM: begin
        if (32'(idx) < NUM_ALARMS) armed_q[idx] = 1'b0;
      end
      OP_RING: begin
        for (int i = 0; i < NUM_ALARMS; i++) begin
          if (armed_q[i] && expiry_q[i] < tv) begin
            armed_q[i] = 1'b0;
            r.kind   = KIND_FIRED;
            r.index  = IDX_W'(i);
            r.expiry = expiry_q[i];
            r.now    = tv;
            r.none   = 1'b0;
            r.last   = 1'b0;
            due_results.push_back(r);
            fired++;
          end
        end
        if (fired > 0) begin
          r = due_results.pop_back();
          r.last = 1'b1;
          due_results.push_back(r);
        end
      end
      default: begin
        r.kind = KIND_QUERY;
        r.now  = '0;
        r.last = 1'b1;
        if (armed_q == '0) begin
          r.index  = '0;
          r.expiry = '0;
          r.none   = 1'b1;
        end else begin
          // starts from all-ones at id 0; only a strictly smaller expiry wins
          best    = '1;
          best_id = '0;
          for (int i = 0; i < NUM_ALARMS; i++) begin
            if (armed_q[i] && expiry_q[i] < best) begin
              best    = expiry_q[i];
              best_id = IDX_W'(i);
            end
          end
          r.index  = best_id;
          r.expiry = best;
          r.none   = 1'b0;
        end
        due_results.push_back(r);
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      armed_q = '0;
      due_results.delete();
      fail_count_o = 0;
    end else begin
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        apply_alarm_item(op_e'(req_mon.op), req_mon.alarm_index, req_mon.time_value);
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none due, expected nothing, got kind %0d index %0d",
                   $time, rsp_mon.result_kind, rsp_mon.result_index);
          $display("  expiry %h now %h none %0d last %0d",
                   rsp_mon.expiry_time, rsp_mon.now_time, rsp_mon.none_armed,
                   rsp_mon.last_result);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", TIME_W'(want.kind), TIME_W'(rsp_mon.result_kind));
          check_field("result_index", TIME_W'(want.index), TIME_W'(rsp_mon.result_index));
          check_field("expiry_time", want.expiry, rsp_mon.expiry_time);
          check_field("now_time", want.now, rsp_mon.now_time);
          check_field("none_armed", TIME_W'(want.none), TIME_W'(rsp_mon.none_armed));
          check_field("last_result", TIME_W'(want.last), TIME_W'(rsp_mon.last_result));
        end
      end
    end
    pending_o = unsigned'(due_results.size());
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ase_pkg::*;

  localparam int unsigned NUM_ALARMS   = NUM_ALARMS_DEF;
  localparam int unsigned RANDOM_ITEMS = 210;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ase_req_if req_bus ();
  ase_rsp_if rsp_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  alarm_set_expiry_scan_core #(.NUM_ALARMS(NUM_ALARMS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  alarm_scan_checker #(.NUM_ALARMS(NUM_ALARMS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_bus),
    .rsp_mon      (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // response side: random back-pressure, plus one long hold on request
  initial begin : rsp_side
    int unsigned n;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_bus.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        rsp_bus.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_bus.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk_i);
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] tv);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= op;
    req_bus.alarm_index <= idx;
    req_bus.time_value  <= tv;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
  endtask

  function automatic logic [TIME_W-1:0] near_time(input logic [TIME_W-1:0] base);
    case ($urandom_range(0, 9))
      0:       near_time = {$urandom, $urandom};
      1:       near_time = TIME_MAX;
      2:       near_time = '0;
      default: near_time = base + TIME_W'($urandom_range(0, 160));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] any_alarm();
    any_alarm = IDX_W'($urandom_range(0, NUM_ALARMS - 1));
  endfunction

  initial begin : stimulus
    logic [TIME_W-1:0] time_base;
    int unsigned       sel;
    int unsigned       k;
    req_bus.valid       <= 1'b0;
    req_bus.op          <= OP_ARM;
    req_bus.alarm_index <= '0;
    req_bus.time_value  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty set: query reports none armed, ring fires nothing
    send_item(OP_QUERY, '0, '0);
    send_item(OP_RING, '0, TIME_MAX);
    // all armed expiries at all-ones: answer is id 0 even with alarm 0 idle
    send_item(OP_ARM, 4'd5, TIME_MAX);
    send_item(OP_ARM, 4'd9, TIME_MAX);
    send_item(OP_QUERY, '1, TIME_MAX);
    send_item(OP_RING, '1, TIME_MAX);
    // equal expiries: lowest id wins
    send_item(OP_ARM, 4'd15, '0);
    send_item(OP_ARM, 4'd0, '0);
    send_item(OP_QUERY, '0, '0);
    // rearm overwrites the stored expiry
    send_item(OP_ARM, 4'd0, 64'd100);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_DISARM, 4'd15, TIME_MAX);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_RING, '0, '0);
    send_item(OP_RING, '0, 64'd101);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_ARM, 4'd3, 64'h5555_5555_5555_5555);
    send_item(OP_ARM, 4'd12, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_ARM, 4'd7, 64'd1);
    send_item(OP_RING, '0, TIME_MAX);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_DISARM, 4'd5, '0);
    send_item(OP_DISARM, 4'd9, '0);
    send_item(OP_DISARM, 4'd2, '0);
    send_item(OP_QUERY, '0, '0);

    // arm every alarm, then send queries and rings while results are held back
    time_base = {$urandom, $urandom};
    idle_on = 1'b0;
    for (k = 0; k < NUM_ALARMS; k++) send_item(OP_ARM, IDX_W'(k), time_base + TIME_W'(k));
    hold_req = 1'b1;
    for (k = 0; k < 24; k++) send_item(OP_QUERY, any_alarm(), {$urandom, $urandom});
    send_item(OP_RING, '0, time_base + TIME_W'(5));
    send_item(OP_RING, '0, time_base + TIME_W'(NUM_ALARMS));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = !(k >= 70 && k < 100) && (k < RANDOM_ITEMS - 60);
      if ($urandom_range(0, 29) == 0) time_base = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        send_item(OP_ARM, any_alarm(), near_time(time_base));
      end else if (sel < 55) begin
        send_item(OP_DISARM, any_alarm(), {$urandom, $urandom});
      end else if (sel < 80) begin
        send_item(OP_RING, any_alarm(), near_time(time_base));
        time_base = time_base + TIME_W'($urandom_range(0, 80));
      end else begin
        send_item(OP_QUERY, any_alarm(), {$urandom, $urandom});
      end
    end
    req_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (NUM_ALARMS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
